>>> src/sapsu_pkg.sv
package sapsu_pkg;

  localparam int TEXT_DEPTH_DEF  = 65536;
  localparam int MAX_PATTERN_DEF = 64;

  localparam logic [1:0] CMD_TEXT    = 2'd0;
  localparam logic [1:0] CMD_SUFFIX  = 2'd1;
  localparam logic [1:0] CMD_PATTERN = 2'd2;
  localparam logic [1:0] CMD_LOCATE  = 2'd3;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  localparam logic CFG_TEXT_LENGTH = 1'b0;
  localparam logic CFG_SEP_COUNT   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOC_RD,
    S_LOC_WAIT,
    S_L_MID,
    S_L_CMP,
    S_L_CHECK,
    S_L_CHECK_CMP,
    S_U_MID,
    S_U_CMP,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_size;    // lo=0, hi=size-1, keep=hi
    logic start_loc;    // rank read from input address
    logic mid_lower;    // mid = lo + (hi-lo)/2, start suffix read
    logic mid_upper;    // mid = lo + (hi-lo+1)/2
    logic mid_lo;       // mid = lo
    logic cmp_start;    // clear n, begin char compare
    logic cmp_step;     // advance compare
    logic upd_lower;
    logic upd_upper;
    logic set_first;
    logic to_upper;     // hi = keep
    logic set_loc;
    logic set_zero;
    logic set_notfound;
    logic set_found;
    logic clr_pattern;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;        // size <= 0
    logic lo_lt_hi;
    logic cmp_done;
    logic cmp_full;     // prefix matched whole pattern
    logic zero_seen;
  } sts_t;

endpackage

>>> src/sapsu_ctrl.sv
module sapsu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go_search,
  input  logic                go_locate,
  input  logic                out_free,
  input  sapsu_pkg::sts_t     sts,
  output sapsu_pkg::ctl_t     ctl,
  output logic                busy,
  output logic                res_valid
);

  sapsu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapsu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sapsu_pkg::S_IDLE: begin
        if (go_locate) begin
          state_nxt = sapsu_pkg::S_LOC_RD;
        end else if (go_search) begin
          if (sts.zero_seen || sts.empty) state_nxt = sapsu_pkg::S_OUT;
          else state_nxt = sapsu_pkg::S_L_MID;
        end
      end
      sapsu_pkg::S_LOC_RD:   state_nxt = sapsu_pkg::S_LOC_WAIT;
      sapsu_pkg::S_LOC_WAIT: state_nxt = sapsu_pkg::S_OUT;
      sapsu_pkg::S_L_MID: begin
        if (sts.lo_lt_hi) state_nxt = sapsu_pkg::S_L_CMP;
        else state_nxt = sapsu_pkg::S_L_CHECK;
      end
      sapsu_pkg::S_L_CMP: begin
        if (sts.cmp_done) state_nxt = sapsu_pkg::S_L_MID;
      end
      sapsu_pkg::S_L_CHECK: state_nxt = sapsu_pkg::S_L_CHECK_CMP;
      sapsu_pkg::S_L_CHECK_CMP: begin
        if (sts.cmp_done) begin
          if (sts.cmp_full) state_nxt = sapsu_pkg::S_U_MID;
          else state_nxt = sapsu_pkg::S_OUT;
        end
      end
      sapsu_pkg::S_U_MID: begin
        if (sts.lo_lt_hi) state_nxt = sapsu_pkg::S_U_CMP;
        else state_nxt = sapsu_pkg::S_OUT;
      end
      sapsu_pkg::S_U_CMP: begin
        if (sts.cmp_done) state_nxt = sapsu_pkg::S_U_MID;
      end
      sapsu_pkg::S_OUT: begin
        if (out_free) state_nxt = sapsu_pkg::S_IDLE;
      end
      default: state_nxt = sapsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    busy      = 1'b1;
    res_valid = 1'b0;
    case (state_r)
      sapsu_pkg::S_IDLE: begin
        busy = 1'b0;
        if (go_locate) begin
          ctl.start_loc = 1'b1;
        end else if (go_search) begin
          ctl.clr_pattern = 1'b1;
          ctl.load_size   = 1'b1;
          if (sts.zero_seen) ctl.set_zero = 1'b1;
          else if (sts.empty) ctl.set_notfound = 1'b1;
        end
      end
      sapsu_pkg::S_LOC_RD: ctl.set_loc = 1'b1;
      sapsu_pkg::S_L_MID: begin
        if (sts.lo_lt_hi) ctl.mid_lower = 1'b1;
        else ctl.mid_lo = 1'b1;
      end
      sapsu_pkg::S_L_CMP: begin
        ctl.cmp_step = 1'b1;
        if (sts.cmp_done) ctl.upd_lower = 1'b1;
      end
      sapsu_pkg::S_L_CHECK: ctl.cmp_start = 1'b1;
      sapsu_pkg::S_L_CHECK_CMP: begin
        ctl.cmp_step = 1'b1;
        if (sts.cmp_done) begin
          if (sts.cmp_full) begin
            ctl.set_first = 1'b1;
            ctl.to_upper  = 1'b1;
          end else begin
            ctl.set_notfound = 1'b1;
          end
        end
      end
      sapsu_pkg::S_U_MID: begin
        if (sts.lo_lt_hi) ctl.mid_upper = 1'b1;
        else ctl.set_found = 1'b1;
      end
      sapsu_pkg::S_U_CMP: begin
        ctl.cmp_step = 1'b1;
        if (sts.cmp_done) ctl.upd_upper = 1'b1;
      end
      sapsu_pkg::S_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/sapsu_datapath.sv
module sapsu_datapath #(
  parameter int TEXT_DEPTH  = sapsu_pkg::TEXT_DEPTH_DEF,
  parameter int MAX_PATTERN = sapsu_pkg::MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [16:0]      cfg_wdata,
  input  logic             in_fire,
  input  logic [1:0]       cmd,
  input  logic [15:0]      address,
  input  logic [15:0]      write_value,
  input  logic [7:0]       pattern_byte,
  input  sapsu_pkg::ctl_t  ctl,
  output sapsu_pkg::sts_t  sts,
  output logic             res_kind,
  output logic [1:0]       res_status,
  output logic [15:0]      res_first,
  output logic [15:0]      res_last,
  output logic [16:0]      res_pos
);

  localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int XW = (AW > 17) ? AW + 2 : 19;

  logic [7:0]  text_mem [TEXT_DEPTH];
  logic [15:0] sfx_mem  [TEXT_DEPTH];
  logic [7:0]  pat_mem  [MAX_PATTERN];

  logic [16:0] tlen_r;
  logic [15:0] sep_r;
  logic [CW-1:0] pcnt_r;
  logic [CW-1:0] plen_r;   // length of the pattern being searched
  logic zero_r;

  logic signed [18:0] lo_r, hi_r, keep_r, mid_r;
  logic [CW-1:0] n_r;
  logic [15:0] ent_r;
  logic [7:0] tch_r, pch_r;
  logic tvalid_r;
  logic [1:0] cph_r;
  logic ch_eq;

  logic signed [18:0] size;
  assign size = $signed({2'b00, tlen_r}) - $signed({3'b000, sep_r});

  // config and pattern collection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r <= 17'd1;
      sep_r  <= 16'd1;
      pcnt_r <= '0;
      zero_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sapsu_pkg::CFG_TEXT_LENGTH) tlen_r <= cfg_wdata;
        else sep_r <= cfg_wdata[15:0];
      end
      if (ctl.clr_pattern) begin
        pcnt_r <= '0;
        zero_r <= 1'b0;
      end else if (in_fire && cmd == sapsu_pkg::CMD_PATTERN) begin
        if (pattern_byte == 8'd0) zero_r <= 1'b1;
        if (pcnt_r < CW'(MAX_PATTERN)) pcnt_r <= pcnt_r + CW'(1);
      end
    end
  end

  // memory ports
  logic [AW-1:0] sfx_raddr, text_raddr;
  logic [15:0]   sfx_rd_r;
  logic [7:0]    text_rd_r, pat_rd_r;
  logic [XW-1:0] tpos;
  logic [PW-1:0] pat_raddr;
  logic [CW-1:0] n_rd;

  // on a matching char the next reads already use n + 1
  assign n_rd       = (ctl.cmp_step && cph_r == 2'd3 && ch_eq) ? n_r + CW'(1) : n_r;
  assign tpos       = XW'(ent_r) + XW'(n_rd);
  assign text_raddr = tpos[AW-1:0];
  assign pat_raddr  = n_rd[PW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && cmd == sapsu_pkg::CMD_TEXT) text_mem[AW'(address)] <= write_value[7:0];
    if (in_fire && cmd == sapsu_pkg::CMD_SUFFIX) sfx_mem[AW'(address)] <= write_value;
    if (in_fire && cmd == sapsu_pkg::CMD_PATTERN && pcnt_r < CW'(MAX_PATTERN))
      pat_mem[pcnt_r[PW-1:0]] <= pattern_byte;
    sfx_rd_r  <= sfx_mem[sfx_raddr];
    text_rd_r <= text_mem[text_raddr];
    pat_rd_r  <= pat_mem[pat_raddr];
  end

  logic signed [18:0] mid_nxt, rank_src;
  logic [18:0] rank_idx;
  always_comb begin
    mid_nxt = lo_r;
    if (ctl.mid_lower) mid_nxt = lo_r + ((hi_r - lo_r) >>> 1);
    else if (ctl.mid_upper) mid_nxt = lo_r + ((hi_r - lo_r + 19'sd1) >>> 1);
    rank_src  = ctl.start_loc ? $signed({3'b000, address}) : mid_nxt;
    rank_idx  = 19'(rank_src) + 19'(sep_r);
    sfx_raddr = AW'(rank_idx);
  end

  logic in_text;
  assign in_text = (tpos < XW'(tlen_r)) && (tpos < XW'(TEXT_DEPTH));

  logic cmp_begin;
  assign cmp_begin = ctl.mid_lower || ctl.mid_upper || ctl.cmp_start;

  assign ch_eq = pch_r == (tvalid_r ? tch_r : 8'd0);

  // compare: phase 0 sfx data latched; 1 char reads issued;
  // 2 char data registered; 3 compare
  logic done_c, full_c;
  always_comb begin
    done_c = 1'b0;
    full_c = 1'b0;
    if (ctl.cmp_step) begin
      if (cph_r == 2'd2 && n_r >= plen_r) begin
        done_c = 1'b1;
        full_c = 1'b1;
      end else if (cph_r == 2'd3 && !ch_eq) begin
        done_c = 1'b1;
      end
    end
  end
  assign sts.cmp_done  = done_c;
  assign sts.cmp_full  = full_c;
  assign sts.empty     = size <= 19'sd0;
  assign sts.lo_lt_hi  = lo_r < hi_r;
  assign sts.zero_seen = zero_r || (in_fire && pattern_byte == 8'd0);

  logic signed [18:0] loc_rank_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cph_r <= 2'd0;
    end else if (cmp_begin || ctl.mid_lo) begin
      cph_r <= 2'd0;
    end else if (ctl.cmp_step || ctl.cmp_start) begin
      if (done_c) cph_r <= 2'd0;
      else if (cph_r == 2'd3) cph_r <= 2'd2;
      else cph_r <= cph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_loc) loc_rank_r <= $signed({3'b000, address});
    if (ctl.clr_pattern)
      plen_r <= (pcnt_r < CW'(MAX_PATTERN)) ? pcnt_r + CW'(1) : pcnt_r;
    if (ctl.load_size) begin
      lo_r   <= '0;
      hi_r   <= size - 19'sd1;
      keep_r <= size - 19'sd1;
    end
    if (ctl.mid_lower || ctl.mid_upper || ctl.mid_lo) mid_r <= mid_nxt;
    if (cmp_begin || ctl.mid_lo) n_r <= '0;
    if (ctl.cmp_step) begin
      if (cph_r == 2'd0) ent_r <= sfx_rd_r;
      if (cph_r == 2'd3 && ch_eq) n_r <= n_rd;
    end
    if (ctl.cmp_step && cph_r == 2'd2) tvalid_r <= in_text;
    tch_r <= text_rd_r;
    pch_r <= pat_rd_r;
    if (ctl.upd_lower) begin
      if (full_c) hi_r <= mid_r;
      else if (pch_r < (tvalid_r ? tch_r : 8'd0)) begin
        hi_r   <= mid_r - 19'sd1;
        keep_r <= mid_r - 19'sd1;
      end else lo_r <= mid_r + 19'sd1;
    end
    if (ctl.to_upper) hi_r <= keep_r;
    if (ctl.upd_upper) begin
      if (full_c) lo_r <= mid_r;
      else hi_r <= mid_r - 19'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_pattern || ctl.start_loc) begin
      res_kind   <= ctl.start_loc;
      res_status <= sapsu_pkg::ST_FOUND;
      res_first  <= '0;
      res_last   <= '0;
      res_pos    <= '0;
    end
    if (ctl.set_zero) res_status <= sapsu_pkg::ST_ZERO;
    if (ctl.set_notfound) begin
      res_status <= sapsu_pkg::ST_NOTFOUND;
      res_first  <= '0;
    end
    if (ctl.set_first) res_first <= lo_r[15:0];
    if (ctl.set_found) res_last <= hi_r[15:0];
    if (ctl.set_loc) begin
      if (loc_rank_r >= size) res_pos <= tlen_r;
      else res_pos <= {1'b0, sfx_rd_r};
    end
  end

endmodule

>>> src/suffix_array_pattern_search_unit.sv
// channel  dir  tdata (low bit first)                                 tuser        tlast
// in_      in   address[15:0] write_value[31:16] pattern_byte[39:32]   cmd[1:0]     pattern_last
// out_     out  search_status[1:0] range_first[17:2] range_last[33:18] result_kind  -
//               text_position[50:34]
// cfg_     in   we, index (0 text_length, 1 separator_count), 17-bit data
// Text, suffix and non-final pattern-byte beats leave the unit idle. A locate passes
// through S_LOC_RD and S_LOC_WAIT before its result is valid; a zero-byte or
// empty-array search result is valid in the cycle after its beat. A search step reads
// one suffix entry, then walks the pattern one character at a time through compare
// phases 2 and 3; two passes of up to ceil(log2(size)) steps plus a check. rst_n is
// synchronous, active low; stores are not cleared. in_tready is low while a search or
// locate runs or its result is not taken.
module suffix_array_pattern_search_unit #(
  parameter int TEXT_DEPTH  = sapsu_pkg::TEXT_DEPTH_DEF,
  parameter int MAX_PATTERN = sapsu_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // address, write_value, pattern_byte
  input  logic [1:0]  in_tuser,   // cmd
  input  logic        in_tlast,   // pattern_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // search_status, range_first, range_last, text_position
  output logic        out_tuser,  // result_kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);

  sapsu_pkg::ctl_t ctl;
  sapsu_pkg::sts_t sts;
  logic busy, res_valid, in_fire;
  logic [1:0] cmd;
  logic kind;
  logic [1:0] status;
  logic [15:0] first, last;
  logic [16:0] pos;

  assign cmd       = in_tuser;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  sapsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go_search (in_fire && cmd == sapsu_pkg::CMD_PATTERN && in_tlast),
    .go_locate (in_fire && cmd == sapsu_pkg::CMD_LOCATE),
    .out_free  (out_tready),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .res_valid (res_valid)
  );

  sapsu_datapath #(
    .TEXT_DEPTH  (TEXT_DEPTH),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .cmd          (cmd),
    .address      (in_tdata[15:0]),
    .write_value  (in_tdata[31:16]),
    .pattern_byte (in_tdata[39:32]),
    .ctl          (ctl),
    .sts          (sts),
    .res_kind     (kind),
    .res_status   (status),
    .res_first    (first),
    .res_last     (last),
    .res_pos      (pos)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = kind;
  assign out_tdata  = {5'd0, pos, last, first, status};

endmodule

>>> bench/tb_top.sv
module tb_top;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [15:0] wval;
    logic [7:0]  pbyte;
    logic        plast;
  } beat_t;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] first;
    logic [15:0] last;
    logic [16:0] pos;
  } result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [16:0] cfg_wdata = '0;

  suffix_array_pattern_search_unit DUT (.*);

  beat_t   beat_q[$];
  beat_t   cur_beat;
  result_t want_q[$];
  int      fail_cnt = 0;
  int      accepted_cnt = 0;
  int      queued_cnt = 0;
  int      send_idle_pct = 37;
  int      recv_idle_pct = 83;
  int      hold_cnt = 0;
  bit      hold_done = 0;

  // shadow of the block's state
  logic [7:0]  txt_mem[65536];
  logic [15:0] sfx_mem[65536];
  logic [7:0]  pat_buf[64];
  int          pat_len = 0;
  bit          pat_zero = 0;
  int          len_reg = 1;
  int          sep_reg = 1;

  // test-side text for building queries
  logic [7:0]  img[64];
  int          img_len;

  initial forever #1 clk = ~clk;

  initial begin
    #20000000;
    $display("[suffix_array_pattern_search_unit] ERROR");
    $finish;
  end

  function automatic int txt_at(int p);
    if (p >= len_reg || p >= 65536) return 0;
    return txt_mem[p];
  endfunction

  function automatic int entry_of(int rank);
    return sfx_mem[(rank + sep_reg) % 65536];
  endfunction

  function automatic int match_len(int rank);
    int p, n;
    p = entry_of(rank);
    n = 0;
    while (n < pat_len && pat_buf[n] == txt_at(p + n)) n++;
    return n;
  endfunction

  function automatic result_t predict_search();
    result_t r;
    int size, lo, hi, keep, mid, m;
    r = '{0, sapsu_pkg::ST_FOUND, 0, 0, 0};
    size = len_reg - sep_reg;
    if (pat_zero) begin
      r.status = sapsu_pkg::ST_ZERO;
      return r;
    end
    if (size <= 0) begin
      r.status = sapsu_pkg::ST_NOTFOUND;
      return r;
    end
    lo = 0;
    hi = size - 1;
    keep = hi;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      m = match_len(mid);
      if (m >= pat_len) hi = mid;
      else if (pat_buf[m] < txt_at(entry_of(mid) + m)) begin
        hi = mid - 1;
        keep = hi;
      end else lo = mid + 1;
    end
    if (match_len(lo) != pat_len) begin
      r.status = sapsu_pkg::ST_NOTFOUND;
      return r;
    end
    r.first = 16'(lo);
    hi = keep;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (match_len(mid) >= pat_len) lo = mid;
      else hi = mid - 1;
    end
    r.last = 16'(hi);
    return r;
  endfunction

  task automatic apply_beat(beat_t b);
    result_t r;
    case (b.cmd)
      sapsu_pkg::CMD_TEXT:   txt_mem[b.addr] = b.wval[7:0];
      sapsu_pkg::CMD_SUFFIX: sfx_mem[b.addr] = b.wval;
      sapsu_pkg::CMD_LOCATE: begin
        r = '{1, sapsu_pkg::ST_FOUND, 0, 0, 0};
        if (int'(b.addr) >= len_reg - sep_reg) r.pos = 17'(len_reg);
        else r.pos = 17'(entry_of(b.addr));
        want_q.push_back(r);
      end
      default: begin
        if (b.pbyte == 0) pat_zero = 1;
        if (pat_len < 64) begin
          pat_buf[pat_len] = b.pbyte;
          pat_len++;
        end
        if (b.plast) begin
          want_q.push_back(predict_search());
          pat_len = 0;
          pat_zero = 0;
        end
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_beat(cur_beat);
        accepted_cnt++;
        if (accepted_cnt == 600) begin
          send_idle_pct = 83;
          recv_idle_pct = 37;
        end else if (accepted_cnt == 1200) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = beat_q.pop_front();
          in_tdata <= {cur_beat.pbyte, cur_beat.wval, cur_beat.addr};
          in_tuser <= cur_beat.cmd;
          in_tlast <= cur_beat.plast;
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (!hold_done && accepted_cnt >= 300) begin
      hold_cnt <= 500;
      hold_done <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    out_tready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // monitor
  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result beat");
        fail_cnt++;
      end else begin
        w = want_q.pop_front();
        if (out_tuser !== w.kind) begin
          $error("result_kind exp %0d got %0d", w.kind, out_tuser);
          fail_cnt++;
        end
        if (out_tdata[1:0] !== w.status) begin
          $error("search_status exp %0d got %0d", w.status, out_tdata[1:0]);
          fail_cnt++;
        end
        if (out_tdata[17:2] !== w.first) begin
          $error("range_first exp %0d got %0d", w.first, out_tdata[17:2]);
          fail_cnt++;
        end
        if (out_tdata[33:18] !== w.last) begin
          $error("range_last exp %0d got %0d", w.last, out_tdata[33:18]);
          fail_cnt++;
        end
        if (out_tdata[50:34] !== w.pos) begin
          $error("text_position exp %0d got %0d", w.pos, out_tdata[50:34]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic push(logic [1:0] c, int a, int v, int pb, bit l);
    beat_q.push_back('{c, a[15:0], v[15:0], pb[7:0], l});
    queued_cnt++;
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_tvalid || want_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_cfg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == sapsu_pkg::CFG_TEXT_LENGTH) len_reg = val & 17'h1FFFF;
    else sep_reg = val & 16'hFFFF;
  endtask

  function automatic int img_at(int p);
    return (p >= img_len) ? 0 : img[p];
  endfunction

  function automatic bit sfx_less(int a, int b);
    int i, ca, cb;
    for (i = 0; i < 70; i++) begin
      ca = img_at(a + i);
      cb = img_at(b + i);
      if (ca != cb) return ca < cb;
      if (ca == 0) return a < b;
    end
    return a < b;
  endfunction

  task automatic pattern_from(int base, int n, bit use_img);
    int i, b;
    for (i = 0; i < n; i++) begin
      b = use_img ? img_at(base + i) : txt_at(base + i);
      if (b == 0) b = $urandom_range(1, 4);
      push(sapsu_pkg::CMD_PATTERN, $urandom, $urandom, b, i == n - 1);
    end
  endtask

  task automatic random_pattern(int n, int hi_byte, bit zero_ok);
    int i, b;
    for (i = 0; i < n; i++) begin
      b = $urandom_range(1, hi_byte);
      if (zero_ok && $urandom_range(9) == 0) b = 0;
      push(sapsu_pkg::CMD_PATTERN, $urandom, $urandom, b, i == n - 1);
    end
  endtask

  task automatic load_text_phase(bit noisy);
    int sa[64];
    int i, j, t, zeros, q, wide;
    img_len = $urandom_range(6, 40);
    wide = $urandom_range(3) == 0;
    zeros = 0;
    for (i = 0; i < img_len; i++) begin
      img[i] = wide ? $urandom_range(1, 255) : $urandom_range(1, 4);
      if (i == img_len - 1 || $urandom_range(7) == 0) begin
        img[i] = 0;
        zeros++;
      end
    end
    for (i = 0; i < img_len; i++) sa[i] = i;
    for (i = 1; i < img_len; i++)
      for (j = i; j > 0 && sfx_less(sa[j], sa[j-1]); j--) begin
        t = sa[j];
        sa[j] = sa[j-1];
        sa[j-1] = t;
      end
    set_cfg(sapsu_pkg::CFG_TEXT_LENGTH, img_len);
    set_cfg(sapsu_pkg::CFG_SEP_COUNT, zeros);
    for (i = 0; i < img_len; i++) begin
      push(sapsu_pkg::CMD_TEXT, i, {8'($urandom_range(255)), img[i]}, $urandom, $urandom);
      push(sapsu_pkg::CMD_SUFFIX, i, sa[i], $urandom, $urandom);
    end
    for (q = 0; q < 60; q++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: pattern_from($urandom_range(img_len - 1), $urandom_range(1, 5), 1);
        4: random_pattern($urandom_range(1, 4), 4, 1);
        5: random_pattern($urandom_range(1, 3), 255, 0);
        6, 7: push(sapsu_pkg::CMD_LOCATE, $urandom_range(img_len + 2), $urandom, $urandom,
                   $urandom);
        8: push(sapsu_pkg::CMD_LOCATE, $urandom, $urandom, $urandom, $urandom);
        default: begin
          if (noisy) push($urandom_range(1), $urandom_range(4096, 65535), $urandom,
                          $urandom, $urandom);
          else random_pattern(1, 4, 0);
        end
      endcase
    end
  endtask

  initial begin
    int i;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset config: empty array
    random_pattern(3, 255, 0);
    push(sapsu_pkg::CMD_LOCATE, 0, 0, 0, 0);
    push(sapsu_pkg::CMD_LOCATE, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    drain();

    // directed on a loaded text
    load_text_phase(0);
    push(sapsu_pkg::CMD_PATTERN, 0, 0, 8'hFF, 1);
    push(sapsu_pkg::CMD_PATTERN, 0, 0, 0, 1);
    for (i = 0; i < 70; i++) push(sapsu_pkg::CMD_PATTERN, 0, 0, (i == 66) ? 0 : 1, i == 69);
    for (i = 0; i < 70; i++) push(sapsu_pkg::CMD_PATTERN, 0, 0, 2, i == 69);
    drain();

    // extreme: full-length text, one rank left
    set_cfg(sapsu_pkg::CFG_TEXT_LENGTH, 65536);
    set_cfg(sapsu_pkg::CFG_SEP_COUNT, 65535);
    for (i = 65530; i < 65536; i++) push(sapsu_pkg::CMD_TEXT, i, $urandom_range(1, 2), 0, 0);
    push(sapsu_pkg::CMD_SUFFIX, 65535, 65530, 0, 0);
    for (i = 0; i < 20; i++) begin
      if (i % 3 == 0) push(sapsu_pkg::CMD_LOCATE, $urandom_range(2), 0, 0, 0);
      else random_pattern($urandom_range(1, 8), 2, 0);
    end
    drain();

    // extreme: more separators than text
    set_cfg(sapsu_pkg::CFG_TEXT_LENGTH, 1);
    set_cfg(sapsu_pkg::CFG_SEP_COUNT, 65535);
    random_pattern(2, 4, 0);
    push(sapsu_pkg::CMD_LOCATE, 0, 0, 0, 0);
    drain();

    while (queued_cnt < 1750) begin
      load_text_phase(1);
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && want_q.size() == 0)
      $display("[suffix_array_pattern_search_unit] OK");
    else
      $display("[suffix_array_pattern_search_unit] ERROR");
    $finish;
  end

endmodule
